// File: design/lpb_pkg.sv
// shared types, codes and constants of the led priority blink pattern unit
// no dependencies; every other design file but lpb_stream_if imports this package
`default_nettype none

package lpb_pkg;

	localparam int SLOT_COUNT_DEF = 3;
	localparam int LEVEL_BITS_DEF = 12;

	localparam int COLOR_W   = 24;
	localparam int MS_W      = 16;
	localparam int OUT_LVL_W = 12;
	localparam int CFG_IDX_W = 2;

	localparam int RED_MAX_RST       = 255;
	localparam int GREEN_MAX_RST     = 255;
	localparam int BLUE_MAX_RST      = 255;
	localparam int BACKLIGHT_MAX_RST = 4095;

	localparam int LUMA_R    = 77;
	localparam int LUMA_G    = 150;
	localparam int LUMA_B    = 29;
	localparam int SCALE_DIV = 255;
	localparam int PAT_STEPS = 15;

	localparam logic [1:0] SRC_NOTIFY    = 2'd0;
	localparam logic [1:0] SRC_BATTERY   = 2'd1;
	localparam logic [1:0] SRC_BLUETOOTH = 2'd2;
	localparam logic [1:0] SRC_BACKLIGHT = 2'd3;

	localparam logic [1:0] FLASH_NONE = 2'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_MAX,
		CFG_GREEN_MAX,
		CFG_BLUE_MAX,
		CFG_BACKLIGHT_MAX
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SELECT,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic [1:0]         source;
		logic [COLOR_W-1:0] color;
		logic [1:0]         flash_mode;
		logic [MS_W-1:0]    on_ms;
		logic [MS_W-1:0]    off_ms;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [1:0]         flash_mode;
		logic [MS_W-1:0]    on_ms;
		logic [MS_W-1:0]    off_ms;
	} slot_t;

	typedef struct packed {
		logic                 target;
		logic                 sync_blink;
		logic                 pattern_write;
		logic [3:0]           pattern_index;
		logic                 step_write;
		logic [MS_W-1:0]      step_ms;
		logic [OUT_LVL_W-1:0] red_level;
		logic [OUT_LVL_W-1:0] green_level;
		logic [OUT_LVL_W-1:0] blue_level;
		logic [OUT_LVL_W-1:0] backlight_level;
		logic                 flash_on;
	} res_t;

endpackage

`default_nettype wire

// File: design/lpb_stream_if.sv
// valid/ready channel carrying one payload of type T per request
// no dependencies; payload types come from lpb_pkg at the place of use
`default_nettype none

interface lpb_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/lpb_scale.sv
// bit-serial level scaler: shift-add multiply max by a byte, then restoring
// divide by 255 one quotient bit per cycle; uses lpb_pkg
`default_nettype none

module lpb_scale #(
	parameter int LEVEL_BITS = lpb_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [LEVEL_BITS-1:0] max_level,
	input  wire logic [7:0]            octet,
	output logic                       busy,
	output logic [LEVEL_BITS-1:0]      level
);
	import lpb_pkg::*;

	localparam int MUL_STEPS = 8;
	localparam int PROD_W    = LEVEL_BITS + MUL_STEPS;
	localparam int LAST      = MUL_STEPS + LEVEL_BITS;
	localparam int CNT_W     = $clog2(LAST + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEVEL_BITS-1:0] mcand_q;
	logic [7:0]            mplier_q;
	logic [PROD_W-1:0]     acc_q;
	logic [7:0]            rem_q;
	logic [LEVEL_BITS-1:0] quo_q;

	logic [8:0] trial;
	logic       qbit;
	logic [7:0] rem_next;

	always_comb begin
		trial    = {rem_q, acc_q[PROD_W-1]};
		qbit     = trial >= 9'(SCALE_DIV);
		rem_next = qbit ? 8'(trial - 9'(SCALE_DIV)) : trial[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(LAST)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= max_level;
			mplier_q <= octet;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (cnt_q < CNT_W'(MUL_STEPS)) begin
				acc_q    <= {acc_q[PROD_W-2:0], 1'b0}
					+ (mplier_q[7] ? PROD_W'(mcand_q) : '0);
				mplier_q <= {mplier_q[6:0], 1'b0};
			end else if (cnt_q == CNT_W'(MUL_STEPS)) begin
				rem_q <= acc_q[PROD_W-1 -: 8];
				acc_q <= acc_q << MUL_STEPS;
			end else begin
				rem_q <= rem_next;
				quo_q <= {quo_q[LEVEL_BITS-2:0], qbit};
				acc_q <= {acc_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign busy  = busy_q;
	assign level = quo_q;

endmodule

`default_nettype wire

// File: design/lpb_blink.sv
// bit-serial blink timing: pattern index on*15/(on+off) in four restoring
// steps, then step duration on/(index+1) in sixteen; uses lpb_pkg
`default_nettype none

module lpb_blink (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [lpb_pkg::MS_W-1:0] on_ms,
	input  wire logic [lpb_pkg::MS_W-1:0] off_ms,
	output logic                          busy,
	output logic [3:0]                    pattern_index,
	output logic [lpb_pkg::MS_W-1:0]      step_ms
);
	import lpb_pkg::*;

	localparam int PAT_BITS = 4;
	localparam int LAST     = PAT_BITS + MS_W;
	localparam int CNT_W    = $clog2(LAST + 1);
	localparam int TOT_W    = MS_W + 1;
	localparam int PROD_W   = MS_W + PAT_BITS;

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TOT_W-1:0]    tot_q;
	logic [TOT_W-1:0]    rem_p_q;
	logic [PAT_BITS-1:0] dlow_q;
	logic [PAT_BITS-1:0] pidx_q;
	logic [MS_W-1:0]     on_q;
	logic [PAT_BITS:0]   dv_q;
	logic [PAT_BITS:0]   rem_d_q;
	logic [MS_W-1:0]     num_q;
	logic [MS_W-1:0]     dur_q;

	logic [PROD_W-1:0]  on_x15;
	logic [TOT_W:0]     trial_p;
	logic               qb_p;
	logic [PAT_BITS+1:0] trial_d;
	logic               qb_d;

	always_comb begin
		on_x15  = PROD_W'(on_ms) * PROD_W'(PAT_STEPS);
		trial_p = {rem_p_q, dlow_q[PAT_BITS-1]};
		qb_p    = trial_p >= {1'b0, tot_q};
		trial_d = {rem_d_q, num_q[MS_W-1]};
		qb_d    = trial_d >= {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(LAST)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tot_q   <= TOT_W'(on_ms) + TOT_W'(off_ms);
			rem_p_q <= TOT_W'(on_x15[PROD_W-1:PAT_BITS]);
			dlow_q  <= on_x15[PAT_BITS-1:0];
			on_q    <= on_ms;
		end else if (busy_q) begin
			if (cnt_q < CNT_W'(PAT_BITS)) begin
				rem_p_q <= qb_p ? TOT_W'(trial_p - {1'b0, tot_q}) : trial_p[TOT_W-1:0];
				dlow_q  <= {dlow_q[PAT_BITS-2:0], 1'b0};
				pidx_q  <= {pidx_q[PAT_BITS-2:0], qb_p};
			end else if (cnt_q == CNT_W'(PAT_BITS)) begin
				dv_q    <= {1'b0, pidx_q} + 1'b1;
				rem_d_q <= '0;
				num_q   <= on_q;
			end else begin
				rem_d_q <= qb_d ? (PAT_BITS+1)'(trial_d - {1'b0, dv_q}) : trial_d[PAT_BITS:0];
				num_q   <= {num_q[MS_W-2:0], 1'b0};
				dur_q   <= {dur_q[MS_W-2:0], qb_d};
			end
		end
	end

	assign busy          = busy_q;
	assign pattern_index = pidx_q;
	assign step_ms       = dur_q;

endmodule

`default_nettype wire

// File: design/led_priority_blink_pattern_unit.sv
// top level: request slots, priority selection, serial scalers and blink timing
// depends on lpb_pkg, lpb_stream_if, lpb_scale and lpb_blink
//
// use: light requests arrive on req (valid/ready, payload lpb_pkg::req_t);
// each request gives exactly one result on res (payload lpb_pkg::res_t).
// non-backlight sources overwrite their slot, then the first lit slot in priority
// order (bluetooth if none is lit) drives an indicator update; a backlight
// request scales the colour luma and leaves the slots alone.
// the four max levels are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// each result waits for the bit-serial scaler (8 multiply steps, one load,
// LEVEL_BITS divide steps) and the blink divider (4 pattern steps, one load,
// 16 duration steps). a new request is taken from the cycle after each result
// is loaded, never while the last one is still in the serial units.
// the result sits in an output register; req is taken again while it waits,
// and a stalled receiver only holds the next result back in the wait state.
// reset clears all slots to unlit solid, the max levels to their defaults
// and the result valid flag.
`default_nettype none

module led_priority_blink_pattern_unit #(
	parameter int SLOT_COUNT = lpb_pkg::SLOT_COUNT_DEF,
	parameter int LEVEL_BITS = lpb_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LEVEL_BITS-1:0]         cfg_data,
	lpb_stream_if.sink                         req,
	lpb_stream_if.source                       res
);
	import lpb_pkg::*;

	localparam int LANES = 3;

	logic [LEVEL_BITS-1:0] red_max_q;
	logic [LEVEL_BITS-1:0] green_max_q;
	logic [LEVEL_BITS-1:0] blue_max_q;
	logic [LEVEL_BITS-1:0] bl_max_q;

	state_t state_q, state_d;
	req_t   req_q;
	slot_t  slots_q [SLOT_COUNT];
	slot_t  sel;
	slot_t  sel_q;
	logic   bl_q;
	res_t   res_q;
	res_t   res_d;
	logic   res_valid_q;

	logic                  accept;
	logic                  start;
	logic                  load;
	logic                  is_bl;
	logic [15:0]           luma_sum;
	logic [7:0]            luma;
	logic                  blink;
	logic                  blk_busy;
	logic [3:0]            pidx;
	logic [MS_W-1:0]       dur;
	logic [LANES-1:0]      scl_busy;
	logic [LEVEL_BITS-1:0] lane_max   [LANES];
	logic [7:0]            lane_octet [LANES];
	logic [LEVEL_BITS-1:0] lane_level [LANES];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_max_q   <= LEVEL_BITS'(RED_MAX_RST);
			green_max_q <= LEVEL_BITS'(GREEN_MAX_RST);
			blue_max_q  <= LEVEL_BITS'(BLUE_MAX_RST);
			bl_max_q    <= LEVEL_BITS'(BACKLIGHT_MAX_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_RED_MAX:       red_max_q   <= cfg_data;
				CFG_GREEN_MAX:     green_max_q <= cfg_data;
				CFG_BLUE_MAX:      blue_max_q  <= cfg_data;
				CFG_BACKLIGHT_MAX: bl_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		start     = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SELECT;
				end
			end
			ST_SELECT: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!(|scl_busy) && !blk_busy && (!res_valid_q || res.ready)) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
	end

	// request slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= '0;
			end
		end else if (accept && req.data.source != SRC_BACKLIGHT) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (int'(req.data.source) == i) begin
					slots_q[i].color      <= req.data.color;
					slots_q[i].flash_mode <= req.data.flash_mode;
					slots_q[i].on_ms      <= req.data.on_ms;
					slots_q[i].off_ms     <= req.data.off_ms;
				end
			end
		end
	end

	// first lit slot, last slot as fallback
	always_comb begin
		sel = slots_q[SLOT_COUNT-1];
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (slots_q[i].color != '0) begin
				sel = slots_q[i];
			end
		end
	end

	always_comb begin
		is_bl    = req_q.source == SRC_BACKLIGHT;
		luma_sum = 16'(LUMA_R) * 16'(req_q.color[23:16])
			+ 16'(LUMA_G) * 16'(req_q.color[15:8])
			+ 16'(LUMA_B) * 16'(req_q.color[7:0]);
		luma     = luma_sum[15:8];
		lane_max[0]   = is_bl ? bl_max_q : red_max_q;
		lane_octet[0] = is_bl ? luma : sel.color[23:16];
		lane_max[1]   = green_max_q;
		lane_octet[1] = sel.color[15:8];
		lane_max[2]   = blue_max_q;
		lane_octet[2] = sel.color[7:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sel_q <= sel;
			bl_q  <= is_bl;
		end
	end

	// serial units
	lpb_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_r (
		.clk(clk), .arst_n(arst_n), .start(start),
		.max_level(lane_max[0]), .octet(lane_octet[0]),
		.busy(scl_busy[0]), .level(lane_level[0])
	);

	lpb_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_g (
		.clk(clk), .arst_n(arst_n), .start(start),
		.max_level(lane_max[1]), .octet(lane_octet[1]),
		.busy(scl_busy[1]), .level(lane_level[1])
	);

	lpb_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_b (
		.clk(clk), .arst_n(arst_n), .start(start),
		.max_level(lane_max[2]), .octet(lane_octet[2]),
		.busy(scl_busy[2]), .level(lane_level[2])
	);

	lpb_blink u_blink (
		.clk(clk), .arst_n(arst_n), .start(start),
		.on_ms(sel.on_ms), .off_ms(sel.off_ms),
		.busy(blk_busy), .pattern_index(pidx), .step_ms(dur)
	);

	// result forming
	always_comb begin
		res_d = '0;
		blink = sel_q.flash_mode != FLASH_NONE && sel_q.off_ms != '0;
		if (bl_q) begin
			res_d.target          = 1'b1;
			res_d.backlight_level = OUT_LVL_W'(lane_level[0]);
		end else begin
			res_d.sync_blink    = blink;
			res_d.pattern_write = blink;
			res_d.pattern_index = blink ? pidx : '0;
			res_d.step_write    = blink && dur != '0;
			res_d.step_ms       = blink ? dur : '0;
			res_d.red_level     = OUT_LVL_W'(lane_level[0]);
			res_d.green_level   = OUT_LVL_W'(lane_level[1]);
			res_d.blue_level    = OUT_LVL_W'(lane_level[2]);
			res_d.flash_on      = sel_q.flash_mode != FLASH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// checks
	a_accept_to_select: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_SELECT)
		else $error("accepted request did not move to slot selection");

	a_idle_units_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !(|scl_busy) && !blk_busy)
		else $error("serial unit still busy while idle");

	a_backlight_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.target |-> res.data.red_level == '0
			&& res.data.sync_blink == 1'b0 && res.data.flash_on == 1'b0)
		else $error("backlight result carries indicator fields");

	a_step_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.step_write |-> res.data.pattern_write && res.data.sync_blink)
		else $error("step duration loaded without pattern");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !load)
		else $error("pending result overwritten");

endmodule

`default_nettype wire
